FILE: src/lsh_pkg.sv
// Shared types, codes and constants of the link sender handshake block.
package lsh_pkg;

	// Raw request codes on the input channel
	localparam logic [2:0] REQ_START      = 3'd0;
	localparam logic [2:0] REQ_TX_DONE    = 3'd1;
	localparam logic [2:0] REQ_TX_TIMEOUT = 3'd2;
	localparam logic [2:0] REQ_GOOD_FRAME = 3'd3;
	localparam logic [2:0] REQ_BAD_FRAME  = 3'd4;
	localparam logic [2:0] REQ_RX_TIMEOUT = 3'd5;

	// Action codes on the result channel
	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_HELLO     = 3'd1;
	localparam logic [2:0] ACT_DATA      = 3'd2;
	localparam logic [2:0] ACT_ARM_GREET = 3'd3;
	localparam logic [2:0] ACT_ARM_ACK   = 3'd4;
	localparam logic [2:0] ACT_FINISH    = 3'd5;

	// Session status codes
	localparam logic [1:0] STAT_NONE    = 2'd0;
	localparam logic [1:0] STAT_SUCCESS = 2'd1;
	localparam logic [1:0] STAT_FAILED  = 2'd2;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_PASSWORD = 2'd0;
	localparam logic [1:0] REG_DEVICE_ID = 2'd1;
	localparam logic [1:0] REG_HS_LIMIT = 2'd2;
	localparam logic [1:0] REG_TX_LIMIT = 2'd3;

	// Register reset values
	localparam logic [7:0]  RST_PASSWORD  = 8'd0;
	localparam logic [15:0] RST_DEVICE_ID = 16'd0;
	localparam logic [7:0]  RST_HS_LIMIT  = 8'd3;
	localparam logic [7:0]  RST_TX_LIMIT  = 8'd3;

	// The transmit retry counter saturates here
	localparam logic [7:0] CNT_MAX = 8'hFF;

	// Default queue depths
	localparam int CMD_DEPTH_DEF = 2;
	localparam int RSP_DEPTH_DEF = 2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  payload_header;
		logic [7:0]  frame_first_byte;
		logic [15:0] frame_node_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  tx_first_byte;
		logic [7:0]  tx_second_byte;
		logic [15:0] tx_node_id;
		logic [1:0]  session_status;
		logic        sequence_now;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  link_password;
		logic [15:0] own_device_id;
		logic [7:0]  handshake_retry_limit;
		logic [7:0]  transmit_retry_limit;
	} cfg_t;

	// Classified event, as handed from the front to the back
	typedef enum logic [2:0] {
		EV_START,
		EV_TX_DONE,
		EV_TX_TIMEOUT,
		EV_GOOD_FRAME,
		EV_BAD_FRAME,
		EV_RX_TIMEOUT,
		EV_IGNORE
	} ev_t;

	typedef struct packed {
		ev_t        ev;
		logic [7:0] header;
		logic       ack_bit;
		logic       pw_ok;
		logic       id_ok;
	} cmd_t;

endpackage

FILE: src/lsh_fifo.sv
// Small register queue used between the front and back and on the result side.
module lsh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == FULLCNT);
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

FILE: src/lsh_front.sv
// Front part: decodes an incoming item into an event and does the frame checks.
module lsh_front (
	input  lsh_pkg::req_t req,
	input  lsh_pkg::cfg_t cfg,
	output lsh_pkg::cmd_t cmd
);
	import lsh_pkg::*;

	// Event decode; unused codes are ignored downstream
	always_comb begin
		unique case (req.req_type)
			REQ_START:      cmd.ev = EV_START;
			REQ_TX_DONE:    cmd.ev = EV_TX_DONE;
			REQ_TX_TIMEOUT: cmd.ev = EV_TX_TIMEOUT;
			REQ_GOOD_FRAME: cmd.ev = EV_GOOD_FRAME;
			REQ_BAD_FRAME:  cmd.ev = EV_BAD_FRAME;
			REQ_RX_TIMEOUT: cmd.ev = EV_RX_TIMEOUT;
			default:        cmd.ev = EV_IGNORE;
		endcase
	end

	// Frame checks against the configured password and ID
	assign cmd.header = req.payload_header;
	assign cmd.ack_bit = req.frame_first_byte[7];
	assign cmd.pw_ok = (req.frame_first_byte == cfg.link_password);
	assign cmd.id_ok = (req.frame_node_id == cfg.own_device_id);
endmodule

FILE: src/lsh_back.sv
// Back part: session state machine, one classified event per cycle unless the result queue is full.
module lsh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  lsh_pkg::cfg_t cfg,
	input  lsh_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  logic          rsp_full,
	output logic          rsp_push,
	output lsh_pkg::rsp_t rsp
);
	import lsh_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HELLO_TX,
		PH_WAIT_GREET,
		PH_DATA_TX,
		PH_WAIT_ACK
	} phase_t;

	phase_t phase_q, phase_d;
	logic seq_q, seq_d;
	logic [7:0] hs_cnt_q, hs_cnt_d;
	logic [7:0] tx_cnt_q, tx_cnt_d;
	logic fresh_q, fresh_d;
	logic [7:0] hdr_q, hdr_d;
	logic [7:0] tx_inc;
	logic [7:0] tx_to;

	assign cmd_pop = !cmd_empty && !rsp_full;
	assign rsp_push = cmd_pop;
	assign tx_inc = (tx_cnt_q == CNT_MAX) ? tx_cnt_q : tx_cnt_q + 8'd1;
	// Count used by a receive timeout: only the first wait after the first data send is free
	assign tx_to = fresh_q ? tx_cnt_q : tx_inc;

	// Next state and action for the event at the queue head
	always_comb begin
		phase_d = phase_q;
		seq_d = seq_q;
		hs_cnt_d = hs_cnt_q;
		tx_cnt_d = tx_cnt_q;
		fresh_d = fresh_q;
		hdr_d = hdr_q;
		rsp = '0;
		rsp.action = ACT_NONE;
		rsp.session_status = STAT_NONE;
		unique case (phase_q)
			PH_IDLE: begin
				if (cmd.ev == EV_START) begin
					hdr_d = cmd.header;
					hs_cnt_d = '0;
					tx_cnt_d = '0;
					fresh_d = 1'b1;
					rsp.action = ACT_HELLO;
					phase_d = PH_HELLO_TX;
				end
			end
			PH_HELLO_TX: begin
				if (cmd.ev == EV_TX_DONE) begin
					rsp.action = ACT_ARM_GREET;
					phase_d = PH_WAIT_GREET;
				end else if (cmd.ev == EV_TX_TIMEOUT) begin
					rsp.action = ACT_HELLO;
				end
			end
			PH_WAIT_GREET: begin
				if (cmd.ev == EV_GOOD_FRAME) begin
					if (cmd.pw_ok && cmd.id_ok) begin
						tx_cnt_d = '0;
						fresh_d = 1'b1;
						rsp.action = ACT_DATA;
						phase_d = PH_DATA_TX;
					end else begin
						rsp.action = ACT_HELLO;
						phase_d = PH_HELLO_TX;
					end
				end else if (cmd.ev == EV_BAD_FRAME) begin
					rsp.action = ACT_HELLO;
					phase_d = PH_HELLO_TX;
				end else if (cmd.ev == EV_RX_TIMEOUT) begin
					if (hs_cnt_q < cfg.handshake_retry_limit) begin
						hs_cnt_d = hs_cnt_q + 8'd1;
						rsp.action = ACT_HELLO;
						phase_d = PH_HELLO_TX;
					end else begin
						rsp.action = ACT_FINISH;
						rsp.session_status = STAT_FAILED;
						phase_d = PH_IDLE;
					end
				end
			end
			PH_DATA_TX: begin
				if (cmd.ev == EV_TX_DONE || cmd.ev == EV_TX_TIMEOUT) begin
					rsp.action = ACT_ARM_ACK;
					phase_d = PH_WAIT_ACK;
				end
			end
			PH_WAIT_ACK: begin
				if (cmd.ev == EV_GOOD_FRAME) begin
					fresh_d = 1'b0;
					if (cmd.id_ok && (cmd.ack_bit == seq_q)) begin
						tx_cnt_d = '0;
						seq_d = !seq_q;
						rsp.action = ACT_FINISH;
						rsp.session_status = STAT_SUCCESS;
						phase_d = PH_IDLE;
					end else if (!cmd.id_ok) begin
						tx_cnt_d = tx_inc;
						if (tx_inc < cfg.transmit_retry_limit) begin
							rsp.action = ACT_DATA;
							phase_d = PH_DATA_TX;
						end else begin
							rsp.action = ACT_FINISH;
							rsp.session_status = STAT_FAILED;
							phase_d = PH_IDLE;
						end
					end else begin
						rsp.action = ACT_ARM_ACK;
					end
				end else if (cmd.ev == EV_BAD_FRAME) begin
					fresh_d = 1'b0;
					rsp.action = ACT_ARM_ACK;
				end else if (cmd.ev == EV_RX_TIMEOUT) begin
					fresh_d = 1'b0;
					tx_cnt_d = tx_to;
					if (tx_to < cfg.transmit_retry_limit) begin
						rsp.action = ACT_DATA;
						phase_d = PH_DATA_TX;
					end else begin
						rsp.action = ACT_FINISH;
						rsp.session_status = STAT_FAILED;
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// Frame bytes follow the action
		if (rsp.action == ACT_HELLO) begin
			rsp.tx_first_byte = cfg.link_password;
			rsp.tx_second_byte = {7'd0, seq_q};
			rsp.tx_node_id = cfg.own_device_id;
		end else if (rsp.action == ACT_DATA) begin
			rsp.tx_first_byte = {seq_q, hdr_d[6:0]};
		end
		rsp.sequence_now = seq_d;
	end

	// Session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seq_q <= 1'b0;
			hs_cnt_q <= '0;
			tx_cnt_q <= '0;
			fresh_q <= 1'b1;
			hdr_q <= '0;
		end else if (cmd_pop) begin
			phase_q <= phase_d;
			seq_q <= seq_d;
			hs_cnt_q <= hs_cnt_d;
			tx_cnt_q <= tx_cnt_d;
			fresh_q <= fresh_d;
			hdr_q <= hdr_d;
		end
	end
endmodule

FILE: src/link_sender_handshake_abp.sv
// Top level of the link sender handshake block: config registers and queues.
//
// Usage: each radio or host event is pushed as one item on the request queue
// (push/full). Every accepted item yields exactly one result item on the
// result queue (empty/pop): the action to take, frame bytes for a hello or
// data send, the session status on finish and the current sequence bit.
// The front decodes each item and checks password and ID; a short command
// queue feeds the back, whose state machine handles one item per cycle while
// the result queue has room. Each result is written into the result queue by
// the back and shows on the result ports once it reaches the queue head.
// Throughput: one item per cycle, set by the state machine step in the back.
// When the consumer stops popping, the result queue fills, then the back
// holds, then the command queue fills and full rises; nothing is dropped.
// Reset clears the queues, the session state (idle, sequence bit 0, counters
// 0) and the registers (password 0, ID 0, both retry limits 3).
// Registers sit at byte addresses 0x0 password, 0x4 device ID, 0x8 handshake
// retry limit, 0xC transmit retry limit; write them only while idle.
module link_sender_handshake_abp #(
	parameter int CMD_DEPTH = lsh_pkg::CMD_DEPTH_DEF,
	parameter int RSP_DEPTH = lsh_pkg::RSP_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lsh_pkg::req_t req_item,
	output logic          full,
	input  logic          pop,
	output lsh_pkg::rsp_t rsp_item,
	output logic          empty,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import lsh_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd_in, cmd_out;
	logic cmd_empty, cmd_pop;
	logic rsp_full, rsp_push;
	rsp_t rsp_in;
	logic cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_password <= RST_PASSWORD;
			cfg_q.own_device_id <= RST_DEVICE_ID;
			cfg_q.handshake_retry_limit <= RST_HS_LIMIT;
			cfg_q.transmit_retry_limit <= RST_TX_LIMIT;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PASSWORD:  cfg_q.link_password <= pwdata[7:0];
				REG_DEVICE_ID: cfg_q.own_device_id <= pwdata[15:0];
				REG_HS_LIMIT:  cfg_q.handshake_retry_limit <= pwdata[7:0];
				REG_TX_LIMIT:  cfg_q.transmit_retry_limit <= pwdata[7:0];
			endcase
		end
	end

	// Register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_PASSWORD:  prdata = {24'd0, cfg_q.link_password};
			REG_DEVICE_ID: prdata = {16'd0, cfg_q.own_device_id};
			REG_HS_LIMIT:  prdata = {24'd0, cfg_q.handshake_retry_limit};
			REG_TX_LIMIT:  prdata = {24'd0, cfg_q.transmit_retry_limit};
		endcase
	end

	lsh_front u_front (
		.req (req_item),
		.cfg (cfg_q),
		.cmd (cmd_in)
	);

	lsh_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	lsh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.rsp_full  (rsp_full),
		.rsp_push  (rsp_push),
		.rsp       (rsp_in)
	);

	lsh_fifo #(
		.WIDTH ($bits(rsp_t)),
		.DEPTH (RSP_DEPTH)
	) u_rsp_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rsp_push),
		.wdata  (rsp_in),
		.full   (rsp_full),
		.pop    (pop),
		.rdata  (rsp_item),
		.empty  (empty)
	);

	// Back never writes into a full result queue
	a_no_rsp_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_push |-> !rsp_full)
		else $error("result written into full queue");

	// An accepted item is waiting for the back on the next cycle
	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !cmd_empty)
		else $error("accepted item lost before the back");

	// Finish always carries a status
	a_finish_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp_item.action == ACT_FINISH) |-> (rsp_item.session_status != STAT_NONE))
		else $error("finish without status");

	// Status only appears with finish
	a_status_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp_item.session_status != STAT_NONE) |-> (rsp_item.action == ACT_FINISH))
		else $error("status without finish");
endmodule
